### rtl/sapp_pkg.sv
// ----------------------------------------------------------------------------
// Standstill auto-park policy: shared package
// Widths, register indices, mode codes and the request/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sapp_pkg;

	localparam int CMD_W     = 16;            // command / feedback field width
	localparam int TIME_W    = 32;            // millisecond timestamp width
	localparam int FRAC_W    = 16;            // filter fraction bits
	localparam int FILT_W    = CMD_W + FRAC_W;
	localparam int ALPHA_W   = 17;
	localparam int LIMIT_W   = 15;
	localparam int DELAY_W   = 16;
	localparam int MODE_W    = 3;
	localparam int NUM_AXES  = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 17;

	localparam int unsigned RETRY_MS = 1000;

	localparam logic [ALPHA_W-1:0] ALPHA_MIN = ALPHA_W'(656);
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

	// chassis mode codes
	localparam logic [MODE_W-1:0] MODE_UNAVAIL    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DEFAULT    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PARK       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_OTHER      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DEFAULT_SW = 3'd4;
	localparam logic [MODE_W-1:0] MODE_PARK_SW    = 3'd5;
	localparam logic [MODE_W-1:0] MODE_OTHER_SW   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_INVALID    = 3'd7;

	// request kinds
	localparam logic REQ_UNLOCK = 1'b0;
	localparam logic REQ_LOCK   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED     = 3'd0,
		REG_AUTO_UNLOCK = 3'd1,
		REG_DELAY       = 3'd2,
		REG_ALPHA       = 3'd3,
		REG_CMD_LIN_LIM = 3'd4,
		REG_CMD_ANG_LIM = 3'd5,
		REG_FB_LIN_LIM  = 3'd6,
		REG_FB_ANG_LIM  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                     lock_ack;
		logic signed [CMD_W-1:0]  cmd_lin_x;
		logic signed [CMD_W-1:0]  cmd_lin_y;
		logic signed [CMD_W-1:0]  cmd_ang_z;
		logic signed [CMD_W-1:0]  cmd_steer;
		logic [MODE_W-1:0]        mode_state;
		logic                     park_allowed;
		logic                     fb_valid;
		logic signed [CMD_W-1:0]  fb_lin_x;
		logic signed [CMD_W-1:0]  fb_lin_y;
		logic signed [CMD_W-1:0]  fb_ang_z;
		logic [TIME_W-1:0]        now_ms;
	} tick_t;

	typedef struct packed {
		logic signed [CMD_W-1:0]  out_lin_x;
		logic signed [CMD_W-1:0]  out_lin_y;
		logic signed [CMD_W-1:0]  out_ang_z;
		logic signed [CMD_W-1:0]  out_steer;
		logic                     request_valid;
		logic                     request_kind;
	} res_t;

endpackage

`default_nettype wire

### rtl/sapp_if.sv
// ----------------------------------------------------------------------------
// Standstill auto-park policy: channel interfaces
// Tick request channel, result channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sapp_tick_if;
	import sapp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     lock_ack;
	logic signed [CMD_W-1:0]  cmd_lin_x;
	logic signed [CMD_W-1:0]  cmd_lin_y;
	logic signed [CMD_W-1:0]  cmd_ang_z;
	logic signed [CMD_W-1:0]  cmd_steer;
	logic [MODE_W-1:0]        mode_state;
	logic                     park_allowed;
	logic                     fb_valid;
	logic signed [CMD_W-1:0]  fb_lin_x;
	logic signed [CMD_W-1:0]  fb_lin_y;
	logic signed [CMD_W-1:0]  fb_ang_z;
	logic [TIME_W-1:0]        now_ms;

	modport source (output valid, lock_ack, cmd_lin_x, cmd_lin_y, cmd_ang_z, cmd_steer,
		mode_state, park_allowed, fb_valid, fb_lin_x, fb_lin_y, fb_ang_z, now_ms,
		input ready);
	modport sink (input valid, lock_ack, cmd_lin_x, cmd_lin_y, cmd_ang_z, cmd_steer,
		mode_state, park_allowed, fb_valid, fb_lin_x, fb_lin_y, fb_ang_z, now_ms,
		output ready);
endinterface

interface sapp_res_if;
	import sapp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [CMD_W-1:0]  out_lin_x;
	logic signed [CMD_W-1:0]  out_lin_y;
	logic signed [CMD_W-1:0]  out_ang_z;
	logic signed [CMD_W-1:0]  out_steer;
	logic                     request_valid;
	logic                     request_kind;

	modport source (output valid, out_lin_x, out_lin_y, out_ang_z, out_steer,
		request_valid, request_kind, input ready);
	modport sink (input valid, out_lin_x, out_lin_y, out_ang_z, out_steer,
		request_valid, request_kind, output ready);
endinterface

interface sapp_cfg_if;
	import sapp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DAT_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/sapp_lane.sv
// ----------------------------------------------------------------------------
// Standstill auto-park policy: one filter lane
// Q16 exponential low-pass update for one axis, with snap to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sapp_lane (
	input  wire logic signed [sapp_pkg::FILT_W-1:0]  filt_q,
	input  wire logic signed [sapp_pkg::CMD_W-1:0]   cmd,
	input  wire logic [sapp_pkg::ALPHA_W-1:0]        alpha,
	input  wire logic [sapp_pkg::LIMIT_W-1:0]        limit,
	input  wire logic                                loaded,
	output logic signed [sapp_pkg::FILT_W-1:0]       filt_next
);
	import sapp_pkg::*;

	localparam int DIFF_W = FILT_W + 1;
	localparam int PROD_W = DIFF_W + ALPHA_W + 1;

	logic signed [FILT_W-1:0] target;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [DIFF_W-1:0] step;
	logic signed [DIFF_W-1:0] sum;
	logic signed [FILT_W-1:0] raw;
	logic [FILT_W:0]          raw_mag;
	logic [FILT_W:0]          lim_q16;

	assign target = {cmd, {FRAC_W{1'b0}}};
	assign diff   = {target[FILT_W-1], target} - {filt_q[FILT_W-1], filt_q};

	// signed product; arithmetic shift floors toward minus infinity
	assign prod = $signed({{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff})
		* $signed({{(PROD_W-ALPHA_W){1'b0}}, alpha});
	assign step = prod[FRAC_W +: DIFF_W];
	assign sum  = {filt_q[FILT_W-1], filt_q} + step;
	assign raw  = loaded ? sum[FILT_W-1:0] : target;

	assign raw_mag = raw[FILT_W-1] ? (FILT_W+1)'(-{raw[FILT_W-1], raw})
		: (FILT_W+1)'({raw[FILT_W-1], raw});
	assign lim_q16 = (FILT_W+1)'({limit, {FRAC_W{1'b0}}});

	assign filt_next = (raw_mag <= lim_q16) ? '0 : raw;

endmodule

`default_nettype wire

### rtl/standstill_auto_park_policy.sv
// ----------------------------------------------------------------------------
// Standstill auto-park policy
// Filters the velocity command, gates it to zero and issues Park / Default
// mode requests after a standstill or on fresh command while parked.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Carries
//  -------  ---  -------------  ----------------------------------------------
//  tick     in   valid/ready    command, mode, permission, feedback, time
//  result   out  valid/ready    gated command, mode request
//  cfg      in   valid/ready    register index and write data (always ready)
//
//  One request enters the input register per cycle unless the result stalls;
//  the decision runs combinationally from that register and the policy state
//  into the result register. Sustained rate is one tick per clock when not
//  stalled, bounded by the filter multiply and policy update in the state loop.
//  Result valid rises as the request moves from input to result register.
//  A stalled result holds the input register; tick.ready falls only then.
//  Reset clears the policy state and loads the register defaults.
//
`default_nettype none

module standstill_auto_park_policy (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sapp_tick_if.sink   tick,
	sapp_res_if.source  result,
	sapp_cfg_if.sink    cfg
);
	import sapp_pkg::*;

	// configuration registers
	logic                enabled_q;
	logic                auto_unlock_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [ALPHA_W-1:0]  alpha_q;      // held already clamped
	logic [LIMIT_W-1:0]  cmd_lin_lim_q;
	logic [LIMIT_W-1:0]  cmd_ang_lim_q;
	logic [LIMIT_W-1:0]  fb_lin_lim_q;
	logic [LIMIT_W-1:0]  fb_ang_lim_q;
	logic [ALPHA_W-1:0]  alpha_wr;

	// policy state
	logic signed [FILT_W-1:0] filt_q [NUM_AXES];
	logic                     loaded_q;
	logic                     ss_valid_q;
	logic [TIME_W-1:0]        ss_ms_q;
	logic                     lr_valid_q;
	logic [TIME_W-1:0]        lr_ms_q;
	logic                     lock_pend_q;
	logic                     unlock_pend_q;

	// pipeline
	logic   s1_valid_q;
	tick_t  tick_s1;
	logic   res_valid_s2;
	res_t   res_s2;
	logic   accept;
	logic   advance;

	// next state and result
	logic signed [CMD_W-1:0]  cmd_v     [NUM_AXES];
	logic [LIMIT_W-1:0]       lane_lim  [NUM_AXES];
	logic signed [FILT_W-1:0] lane_next [NUM_AXES];
	logic signed [FILT_W-1:0] n_filt    [NUM_AXES];
	logic                     n_loaded;
	logic                     n_ss_valid;
	logic [TIME_W-1:0]        n_ss_ms;
	logic                     n_lr_valid;
	logic [TIME_W-1:0]        n_lr_ms;
	logic                     n_lock;
	logic                     n_unlock;
	logic                     fzero;
	logic                     switching;
	logic                     dflt_mode;
	logic                     is_park;
	logic                     fb_moving;
	logic                     zero_out;
	logic                     req_valid;
	logic                     req_kind;
	logic [TIME_W-1:0]        now;
	res_t                     res_d;

	// ------------------------------------------------------------------
	// Handshake: input register, result register
	// ------------------------------------------------------------------
	assign advance    = s1_valid_q && (!res_valid_s2 || result.ready);
	assign tick.ready = !s1_valid_q || advance;
	assign accept     = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;

	assign result.valid         = res_valid_s2;
	assign result.out_lin_x     = res_s2.out_lin_x;
	assign result.out_lin_y     = res_s2.out_lin_y;
	assign result.out_ang_z     = res_s2.out_ang_z;
	assign result.out_steer     = res_s2.out_steer;
	assign result.request_valid = res_s2.request_valid;
	assign result.request_kind  = res_s2.request_kind;

	// ------------------------------------------------------------------
	// Register writes; alpha is clamped to its legal span on the way in
	// ------------------------------------------------------------------
	always_comb begin
		alpha_wr = cfg.data[ALPHA_W-1:0];
		if (alpha_wr < ALPHA_MIN) begin
			alpha_wr = ALPHA_MIN;
		end else if (alpha_wr > ALPHA_ONE) begin
			alpha_wr = ALPHA_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b0;
			auto_unlock_q <= 1'b1;
			delay_q       <= DELAY_W'(2000);
			alpha_q       <= ALPHA_W'(6554);
			cmd_lin_lim_q <= LIMIT_W'(10);
			cmd_ang_lim_q <= LIMIT_W'(10);
			fb_lin_lim_q  <= LIMIT_W'(10);
			fb_ang_lim_q  <= LIMIT_W'(10);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ENABLED:     enabled_q     <= cfg.data[0];
				REG_AUTO_UNLOCK: auto_unlock_q <= cfg.data[0];
				REG_DELAY:       delay_q       <= cfg.data[DELAY_W-1:0];
				REG_ALPHA:       alpha_q       <= alpha_wr;
				REG_CMD_LIN_LIM: cmd_lin_lim_q <= cfg.data[LIMIT_W-1:0];
				REG_CMD_ANG_LIM: cmd_ang_lim_q <= cfg.data[LIMIT_W-1:0];
				REG_FB_LIN_LIM:  fb_lin_lim_q  <= cfg.data[LIMIT_W-1:0];
				REG_FB_ANG_LIM:  fb_ang_lim_q  <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Filter lanes: lin_x, lin_y use the linear limit, ang_z, steer angular
	// ------------------------------------------------------------------
	assign cmd_v[0] = tick_s1.cmd_lin_x;
	assign cmd_v[1] = tick_s1.cmd_lin_y;
	assign cmd_v[2] = tick_s1.cmd_ang_z;
	assign cmd_v[3] = tick_s1.cmd_steer;

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
		assign lane_lim[g] = (g < 2) ? cmd_lin_lim_q : cmd_ang_lim_q;
		sapp_lane u_lane (
			.filt_q    (filt_q[g]),
			.cmd       (cmd_v[g]),
			.alpha     (alpha_q),
			.limit     (lane_lim[g]),
			.loaded    (loaded_q),
			.filt_next (lane_next[g])
		);
	end

	function automatic logic [CMD_W:0] abs_cmd(input logic signed [CMD_W-1:0] v);
		logic signed [CMD_W:0] x;
		x = {v[CMD_W-1], v};
		return v[CMD_W-1] ? (CMD_W+1)'(-x) : (CMD_W+1)'(x);
	endfunction

	// retry spacing: open when no earlier request or it is old enough
	function automatic logic retry_open(input logic valid, input logic [TIME_W-1:0] last,
		input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] d;
		d = t - last;
		return !valid || (d >= TIME_W'(RETRY_MS));
	endfunction

	assign now = tick_s1.now_ms;

	assign fb_moving = !tick_s1.fb_valid
		|| (32'(abs_cmd(tick_s1.fb_lin_x)) > 32'(fb_lin_lim_q))
		|| (32'(abs_cmd(tick_s1.fb_lin_y)) > 32'(fb_lin_lim_q))
		|| (32'(abs_cmd(tick_s1.fb_ang_z)) > 32'(fb_ang_lim_q));

	assign switching = (tick_s1.mode_state == MODE_DEFAULT_SW)
		|| (tick_s1.mode_state == MODE_PARK_SW) || (tick_s1.mode_state == MODE_OTHER_SW);
	assign dflt_mode = (tick_s1.mode_state == MODE_DEFAULT)
		|| (tick_s1.mode_state == MODE_DEFAULT_SW);
	assign is_park = (tick_s1.mode_state == MODE_PARK) || (tick_s1.mode_state == MODE_PARK_SW);

	// ------------------------------------------------------------------
	// Policy decision
	// ------------------------------------------------------------------
	always_comb begin
		n_filt     = filt_q;
		n_loaded   = loaded_q;
		n_ss_valid = ss_valid_q;
		n_ss_ms    = ss_ms_q;
		n_lr_valid = lr_valid_q;
		n_lr_ms    = lr_ms_q;
		n_lock     = lock_pend_q;
		n_unlock   = unlock_pend_q;
		zero_out   = 1'b0;
		req_valid  = 1'b0;
		req_kind   = REQ_UNLOCK;
		fzero      = 1'b1;

		if (!enabled_q) begin
			// disabled: everything cleared, command passes
			for (int i = 0; i < NUM_AXES; i++) begin
				n_filt[i] = '0;
			end
			n_loaded   = 1'b0;
			n_ss_valid = 1'b0;
			n_ss_ms    = '0;
			n_lr_valid = 1'b0;
			n_lr_ms    = '0;
			n_lock     = 1'b0;
			n_unlock   = 1'b0;
		end else begin
			if (tick_s1.lock_ack) begin
				n_lock = 1'b1;
			end
			n_filt   = lane_next;
			n_loaded = 1'b1;
			for (int i = 0; i < NUM_AXES; i++) begin
				if (lane_next[i] != '0) begin
					fzero = 1'b0;
				end
			end

			if ((tick_s1.mode_state == MODE_UNAVAIL) || (tick_s1.mode_state == MODE_INVALID)) begin
				n_ss_valid = 1'b0;
				n_lr_valid = 1'b0;
				n_lock     = 1'b0;
				n_unlock   = 1'b0;
			end else if (n_unlock && !(dflt_mode && !switching)) begin
				// unlock still outstanding: hold output, retry on command
				zero_out = 1'b1;
				if (!fzero && auto_unlock_q && retry_open(n_lr_valid, n_lr_ms, now)) begin
					n_lr_valid = 1'b1;
					n_lr_ms    = now;
					req_valid  = 1'b1;
				end
			end else begin
				if (n_unlock) begin
					// unlock confirmed by a settled Default mode
					n_unlock   = 1'b0;
					n_lock     = 1'b0;
					n_lr_valid = 1'b0;
				end
				if (switching) begin
					n_ss_valid = 1'b0;
					if (n_lock || n_unlock) begin
						zero_out = 1'b1;
					end
				end else if (is_park) begin
					n_ss_valid = 1'b0;
					n_lock     = 1'b1;
					zero_out   = 1'b1;
					if (!fzero && auto_unlock_q) begin
						if (!n_unlock) begin
							n_lr_valid = 1'b0;
						end
						n_unlock = 1'b1;
						if (retry_open(n_lr_valid, n_lr_ms, now)) begin
							n_lr_valid = 1'b1;
							n_lr_ms    = now;
							req_valid  = 1'b1;
						end
					end
				end else if (!tick_s1.park_allowed) begin
					n_ss_valid = 1'b0;
					n_lr_valid = 1'b0;
					n_lock     = 1'b0;
				end else if (!dflt_mode) begin
					n_ss_valid = 1'b0;
					n_lock     = 1'b0;
				end else if (!fzero) begin
					n_ss_valid = 1'b0;
					if (n_lock) begin
						n_lr_valid = 1'b0;
					end
					n_lock = 1'b0;
				end else if (fb_moving) begin
					n_ss_valid = 1'b0;
				end else if (!n_ss_valid) begin
					// standstill starts now
					n_ss_valid = 1'b1;
					n_ss_ms    = now;
				end else if ((now - n_ss_ms) >= {{(TIME_W-DELAY_W){1'b0}}, delay_q}) begin
					// standstill long enough: gate and ask for Park
					zero_out = 1'b1;
					if (retry_open(n_lr_valid, n_lr_ms, now)) begin
						n_lr_valid = 1'b1;
						n_lr_ms    = now;
						req_valid  = 1'b1;
						req_kind   = REQ_LOCK;
					end
				end
			end
		end

		res_d.out_lin_x     = zero_out ? '0 : tick_s1.cmd_lin_x;
		res_d.out_lin_y     = zero_out ? '0 : tick_s1.cmd_lin_y;
		res_d.out_ang_z     = zero_out ? '0 : tick_s1.cmd_ang_z;
		res_d.out_steer     = zero_out ? '0 : tick_s1.cmd_steer;
		res_d.request_valid = req_valid;
		res_d.request_kind  = req_valid ? req_kind : REQ_UNLOCK;
	end

	// ------------------------------------------------------------------
	// Control and state registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			res_valid_s2  <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				filt_q[i] <= '0;
			end
			loaded_q      <= 1'b0;
			ss_valid_q    <= 1'b0;
			ss_ms_q       <= '0;
			lr_valid_q    <= 1'b0;
			lr_ms_q       <= '0;
			lock_pend_q   <= 1'b0;
			unlock_pend_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				res_valid_s2  <= 1'b1;
				filt_q        <= n_filt;
				loaded_q      <= n_loaded;
				ss_valid_q    <= n_ss_valid;
				ss_ms_q       <= n_ss_ms;
				lr_valid_q    <= n_lr_valid;
				lr_ms_q       <= n_lr_ms;
				lock_pend_q   <= n_lock;
				unlock_pend_q <= n_unlock;
			end else if (result.ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1.lock_ack     <= tick.lock_ack;
			tick_s1.cmd_lin_x    <= tick.cmd_lin_x;
			tick_s1.cmd_lin_y    <= tick.cmd_lin_y;
			tick_s1.cmd_ang_z    <= tick.cmd_ang_z;
			tick_s1.cmd_steer    <= tick.cmd_steer;
			tick_s1.mode_state   <= tick.mode_state;
			tick_s1.park_allowed <= tick.park_allowed;
			tick_s1.fb_valid     <= tick.fb_valid;
			tick_s1.fb_lin_x     <= tick.fb_lin_x;
			tick_s1.fb_lin_y     <= tick.fb_lin_y;
			tick_s1.fb_ang_z     <= tick.fb_ang_z;
			tick_s1.now_ms       <= tick.now_ms;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_lock_gates: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.request_valid && (result.request_kind == REQ_LOCK)
		|-> (result.out_lin_x == '0) && (result.out_lin_y == '0)
			&& (result.out_ang_z == '0) && (result.out_steer == '0))
		else $error("lock request issued with ungated command");

	a_kind_only_req: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.request_valid |-> result.request_kind == REQ_UNLOCK)
		else $error("request kind set without a request");

	a_req_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_valid |=> lr_valid_q && (lr_ms_q == $past(now)))
		else $error("issued request not recorded for retry spacing");

	a_disabled_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !enabled_q |=> !loaded_q && !lock_pend_q && !unlock_pend_q && !ss_valid_q)
		else $error("state not cleared while disabled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> tick.ready)
		else $error("input stalled with empty input register");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Standstill auto-park policy: self-checking testbench
// Walks a table of directed tick requests, then runs phases of random park
// and unlock cycles mixed with noise. Each phase has its own register
// settings. Every result is checked against a cycle-free model of the policy or a typed expectation.
// ----------------------------------------------------------------------------

module testbench;
	import sapp_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 200000;
	localparam int unsigned HOLD_CYCLES     = 200;
	localparam int unsigned N_PHASES        = 8;
	localparam int unsigned ITEMS_PER_PHASE = 100;
	localparam int unsigned IDLE_PCT        = 16;

	// one directed row: optional register write first, then the tick request
	typedef struct {
		bit       wr;
		cfg_reg_t idx;
		int       val;
		tick_t    t;
		bit       fixed;    // expectation typed in below, not predicted
		res_t     r;
	} dir_row_t;

	typedef struct {
		bit   fixed;
		res_t r;
	} preset_t;

	logic clk = 1'b0;
	logic arst_n;

	sapp_tick_if tick_ch ();
	sapp_res_if  res_ch ();
	sapp_cfg_if  cfg_ch ();

	standstill_auto_park_policy dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Policy model: register shadow (reset values) and policy state
	// ------------------------------------------------------------------
	bit                  en_r          = 1'b0;
	bit                  auto_unlock_r = 1'b1;
	logic [DELAY_W-1:0]  delay_r       = 16'd2000;
	logic [ALPHA_W-1:0]  alpha_r       = 17'd6554;
	logic [LIMIT_W-1:0]  cmd_lin_lim_r = 15'd10;
	logic [LIMIT_W-1:0]  cmd_ang_lim_r = 15'd10;
	logic [LIMIT_W-1:0]  fb_lin_lim_r  = 15'd10;
	logic [LIMIT_W-1:0]  fb_ang_lim_r  = 15'd10;

	longint              filt [NUM_AXES];   // Q16 filtered command per axis
	bit                  filt_loaded;
	bit                  still_valid;       // standstill timer running
	logic [TIME_W-1:0]   still_ms;
	bit                  req_seen;          // a mode request time is on record
	logic [TIME_W-1:0]   req_ms;
	bit                  lock_pend;
	bit                  unlock_pend;

	res_t    due_results [$];   // expected results, oldest first
	preset_t preset_q [$];      // per sent tick: typed expectation, if any
	int unsigned fault_cnt = 0;
	int unsigned sent_cnt  = 0;
	logic [TIME_W-1:0] clock_ms = '0;  // chassis time used by the generator

	bit quiet     = 1'b0;   // no idling on either side
	bit hold_ask  = 1'b0;   // stimulus asks for a long result stall
	bit hold_done = 1'b0;   // set by the result side once the stall is over

	initial begin
		foreach (filt[i])
			filt[i] = 0;
		filt_loaded = 1'b0;
		still_valid = 1'b0;
		still_ms    = '0;
		req_seen    = 1'b0;
		req_ms      = '0;
		lock_pend   = 1'b0;
		unlock_pend = 1'b0;
	end

	// Mode requests at least RETRY_MS apart, wrap-safe; records the time on grant
	function automatic bit mode_request_free(logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] since;
		since = now - req_ms;
		if (req_seen && since < RETRY_MS)
			return 1'b0;
		req_seen = 1'b1;
		req_ms   = now;
		return 1'b1;
	endfunction

	function automatic longint mag16(logic signed [CMD_W-1:0] v);
		return (v < 0) ? -longint'(v) : longint'(v);
	endfunction

	// Advances the policy state by one tick and returns its result
	function automatic res_t park_policy_step(tick_t t);
		res_t              r;
		longint            cmd [NUM_AXES];
		longint            target, lim, mag, alpha_q;
		logic [MODE_W-1:0] m;
		logic [TIME_W-1:0] elapsed;
		bit                zero_out, fzero, sw, done;

		r        = '0;
		zero_out = 1'b0;
		fzero    = 1'b1;
		done     = 1'b0;
		cmd[0]   = t.cmd_lin_x;
		cmd[1]   = t.cmd_lin_y;
		cmd[2]   = t.cmd_ang_z;
		cmd[3]   = t.cmd_steer;

		if (!en_r) begin
			// disabled: everything forgotten, lock_ack ignored
			foreach (filt[i])
				filt[i] = 0;
			filt_loaded = 1'b0;
			still_valid = 1'b0;
			still_ms    = '0;
			req_seen    = 1'b0;
			req_ms      = '0;
			lock_pend   = 1'b0;
			unlock_pend = 1'b0;
		end else begin
			if (t.lock_ack)
				lock_pend = 1'b1;
			alpha_q = alpha_r;
			if (alpha_q < longint'(ALPHA_MIN))
				alpha_q = ALPHA_MIN;
			if (alpha_q > longint'(ALPHA_ONE))
				alpha_q = ALPHA_ONE;
			for (int i = 0; i < NUM_AXES; i++) begin
				target = cmd[i] * 65536;
				lim    = longint'(i < 2 ? cmd_lin_lim_r : cmd_ang_lim_r) * 65536;
				if (!filt_loaded)
					filt[i] = target;
				else
					filt[i] = filt[i] + (((target - filt[i]) * alpha_q) >>> FRAC_W);
				mag = (filt[i] < 0) ? -filt[i] : filt[i];
				if (mag <= lim)
					filt[i] = 0;
				if (filt[i] != 0)
					fzero = 1'b0;
			end
			filt_loaded = 1'b1;

			m = t.mode_state;
			if (m == MODE_UNAVAIL || m == MODE_INVALID) begin
				still_valid = 1'b0;
				req_seen    = 1'b0;
				lock_pend   = 1'b0;
				unlock_pend = 1'b0;
			end else begin
				sw = (m >= MODE_DEFAULT_SW);
				if (sw)
					m = m - 3'd3;
				if (unlock_pend) begin
					if (m == MODE_DEFAULT && !sw) begin
						unlock_pend = 1'b0;
						lock_pend   = 1'b0;
						req_seen    = 1'b0;
					end else begin
						zero_out = 1'b1;
						if (!fzero && auto_unlock_r && mode_request_free(t.now_ms))
							r.request_valid = 1'b1;
						done = 1'b1;
					end
				end
				if (done) begin
					// unlock still outstanding
				end else if (sw) begin
					still_valid = 1'b0;
					if (lock_pend || unlock_pend)
						zero_out = 1'b1;
				end else if (m == MODE_PARK) begin
					still_valid = 1'b0;
					lock_pend   = 1'b1;
					zero_out    = 1'b1;
					if (!fzero && auto_unlock_r) begin
						if (!unlock_pend)
							req_seen = 1'b0;
						unlock_pend = 1'b1;
						if (mode_request_free(t.now_ms))
							r.request_valid = 1'b1;
					end
				end else if (!t.park_allowed) begin
					still_valid = 1'b0;
					req_seen    = 1'b0;
					lock_pend   = 1'b0;
				end else if (m != MODE_DEFAULT) begin
					still_valid = 1'b0;
					lock_pend   = 1'b0;
				end else if (!fzero) begin
					still_valid = 1'b0;
					if (lock_pend)
						req_seen = 1'b0;
					lock_pend = 1'b0;
				end else if (!t.fb_valid ||
						mag16(t.fb_lin_x) > longint'(fb_lin_lim_r) ||
						mag16(t.fb_lin_y) > longint'(fb_lin_lim_r) ||
						mag16(t.fb_ang_z) > longint'(fb_ang_lim_r)) begin
					still_valid = 1'b0;
				end else if (!still_valid) begin
					still_valid = 1'b1;
					still_ms    = t.now_ms;
				end else begin
					elapsed = t.now_ms - still_ms;
					if (elapsed >= TIME_W'(delay_r)) begin
						zero_out = 1'b1;
						if (mode_request_free(t.now_ms)) begin
							r.request_valid = 1'b1;
							r.request_kind  = REQ_LOCK;
						end
					end
				end
			end
		end

		r.out_lin_x = zero_out ? '0 : t.cmd_lin_x;
		r.out_lin_y = zero_out ? '0 : t.cmd_lin_y;
		r.out_ang_z = zero_out ? '0 : t.cmd_ang_z;
		r.out_steer = zero_out ? '0 : t.cmd_steer;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Monitors, all sampling at the rising edge
	// ------------------------------------------------------------------

	// register writes go into the shadow as the block takes them
	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_reg_t'(cfg_ch.index))
				REG_ENABLED:     en_r          = cfg_ch.data[0];
				REG_AUTO_UNLOCK: auto_unlock_r = cfg_ch.data[0];
				REG_DELAY:       delay_r       = cfg_ch.data[DELAY_W-1:0];
				REG_ALPHA:       alpha_r       = cfg_ch.data[ALPHA_W-1:0];
				REG_CMD_LIN_LIM: cmd_lin_lim_r = cfg_ch.data[LIMIT_W-1:0];
				REG_CMD_ANG_LIM: cmd_ang_lim_r = cfg_ch.data[LIMIT_W-1:0];
				REG_FB_LIN_LIM:  fb_lin_lim_r  = cfg_ch.data[LIMIT_W-1:0];
				REG_FB_ANG_LIM:  fb_ang_lim_r  = cfg_ch.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// accepted tick request: run the model, queue what should come out
	always @(posedge clk) begin
		tick_t   t;
		res_t    pred;
		preset_t ps;
		if (arst_n && tick_ch.valid && tick_ch.ready) begin
			t = '{tick_ch.lock_ack, tick_ch.cmd_lin_x, tick_ch.cmd_lin_y, tick_ch.cmd_ang_z,
				tick_ch.cmd_steer, tick_ch.mode_state, tick_ch.park_allowed, tick_ch.fb_valid,
				tick_ch.fb_lin_x, tick_ch.fb_lin_y, tick_ch.fb_ang_z, tick_ch.now_ms};
			pred = park_policy_step(t);
			ps   = preset_q.pop_front();
			due_results.push_back(ps.fixed ? ps.r : pred);
		end
	end

	task automatic check_field(string nm, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
			fault_cnt++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: result with nothing expected, actual %0d %0d %0d %0d %0b %0b",
					$time, res_ch.out_lin_x, res_ch.out_lin_y, res_ch.out_ang_z,
					res_ch.out_steer, res_ch.request_valid, res_ch.request_kind);
				fault_cnt++;
			end else begin
				want = due_results.pop_front();
				check_field("out_lin_x", want.out_lin_x, res_ch.out_lin_x);
				check_field("out_lin_y", want.out_lin_y, res_ch.out_lin_y);
				check_field("out_ang_z", want.out_ang_z, res_ch.out_ang_z);
				check_field("out_steer", want.out_steer, res_ch.out_steer);
				check_field("request_valid", want.request_valid, res_ch.request_valid);
				check_field("request_kind", want.request_kind, res_ch.request_kind);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random stalls, one long hold-off when asked
	// ------------------------------------------------------------------
	initial begin
		int unsigned hold_cnt;
		hold_cnt = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ask && !hold_done) begin
				// long stall: result and input registers fill, tick.ready drops
				res_ch.ready <= 1'b0;
				hold_cnt++;
				if (hold_cnt >= HOLD_CYCLES)
					hold_done = 1'b1;
			end else if (quiet) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic tick_t tk(bit ack, int cx, int cy, int cz, int cs,
			logic [MODE_W-1:0] mode, bit allowed, bit fbv, int fx, int fy, int fz,
			logic [TIME_W-1:0] now);
		return '{ack, 16'(cx), 16'(cy), 16'(cz), 16'(cs), mode, allowed, fbv,
			16'(fx), 16'(fy), 16'(fz), now};
	endfunction

	function automatic res_t rs(int x, int y, int z, int s, bit v, bit k);
		return '{16'(x), 16'(y), 16'(z), 16'(s), v, k};
	endfunction

	// zero half the time, otherwise anywhere within +/- lim
	function automatic logic signed [CMD_W-1:0] near_zero(int lim);
		if ($urandom_range(0, 1) == 0)
			return '0;
		return 16'(int'($urandom_range(0, 2 * lim)) - lim);
	endfunction

	// one tick of chassis life: time moves on, command either moving or at rest
	function automatic tick_t scene_tick(logic [MODE_W-1:0] mode, bit moving);
		tick_t t;
		t = '0;
		if ($urandom_range(0, 99) < 3)
			clock_ms = $urandom;
		else
			clock_ms += $urandom_range(0, 400);
		t.now_ms       = clock_ms;
		t.mode_state   = mode;
		t.park_allowed = ($urandom_range(0, 99) < 95);
		t.fb_valid     = ($urandom_range(0, 99) < 95);
		if (moving) begin
			t.cmd_lin_x = 16'($urandom);
			t.cmd_lin_y = 16'($urandom);
			t.cmd_ang_z = 16'($urandom);
			t.cmd_steer = 16'($urandom);
			t.fb_lin_x  = 16'($urandom);
			t.fb_lin_y  = 16'($urandom);
			t.fb_ang_z  = 16'($urandom);
		end else begin
			t.cmd_lin_x = near_zero(cmd_lin_lim_r);
			t.cmd_lin_y = near_zero(cmd_lin_lim_r);
			t.cmd_ang_z = near_zero(cmd_ang_lim_r);
			t.cmd_steer = near_zero(cmd_ang_lim_r);
			t.fb_lin_x  = near_zero(fb_lin_lim_r);
			t.fb_lin_y  = near_zero(fb_lin_lim_r);
			t.fb_ang_z  = near_zero(fb_ang_lim_r);
			if ($urandom_range(0, 99) < 5)
				t.fb_lin_x = 16'($urandom);
		end
		return t;
	endfunction

	// valid stays high between back-to-back requests; a gap lowers it first
	task automatic send_tick(tick_t t, bit fixed, res_t r);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		preset_q.push_back(preset_t'{fixed, r});
		tick_ch.valid        <= 1'b1;
		tick_ch.lock_ack     <= t.lock_ack;
		tick_ch.cmd_lin_x    <= t.cmd_lin_x;
		tick_ch.cmd_lin_y    <= t.cmd_lin_y;
		tick_ch.cmd_ang_z    <= t.cmd_ang_z;
		tick_ch.cmd_steer    <= t.cmd_steer;
		tick_ch.mode_state   <= t.mode_state;
		tick_ch.park_allowed <= t.park_allowed;
		tick_ch.fb_valid     <= t.fb_valid;
		tick_ch.fb_lin_x     <= t.fb_lin_x;
		tick_ch.fb_lin_y     <= t.fb_lin_y;
		tick_ch.fb_ang_z     <= t.fb_ang_z;
		tick_ch.now_ms       <= t.now_ms;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		@(negedge clk);
		sent_cnt++;
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		tick_ch.valid <= 1'b0;
		@(negedge clk);
		while (due_results.size() != 0 || preset_q.size() != 0)
			@(negedge clk);
	endtask

	// caller lowers cfg valid after the last write of a group
	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= CFG_DAT_W'(val);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_settings(bit en, bit au, int unsigned dly, int unsigned alpha,
			int unsigned l_cl, int unsigned l_ca, int unsigned l_fl, int unsigned l_fa);
		write_reg(REG_ENABLED, en);
		write_reg(REG_AUTO_UNLOCK, au);
		write_reg(REG_DELAY, dly);
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_CMD_LIN_LIM, l_cl);
		write_reg(REG_CMD_ANG_LIM, l_ca);
		write_reg(REG_FB_LIN_LIM, l_fl);
		write_reg(REG_FB_ANG_LIM, l_fa);
		cfg_ch.valid <= 1'b0;
	endtask

	// drive up, stand still until the lock, park, then command away again
	task automatic park_cycle();
		tick_t       t;
		int unsigned n_still;
		repeat ($urandom_range(1, 4))
			send_tick(scene_tick(MODE_DEFAULT, 1'b1), 1'b0, '0);
		n_still = 2 + delay_r / 200 + $urandom_range(0, 4);
		if (n_still > 30)
			n_still = 30;
		repeat (n_still)
			send_tick(scene_tick(MODE_DEFAULT, 1'b0), 1'b0, '0);
		t = scene_tick($urandom_range(0, 1) ? MODE_PARK_SW : MODE_DEFAULT, 1'b0);
		t.lock_ack = 1'b1;
		send_tick(t, 1'b0, '0);
		repeat ($urandom_range(0, 2))
			send_tick(scene_tick(MODE_PARK_SW, 1'b0), 1'b0, '0);
		repeat ($urandom_range(1, 4))
			send_tick(scene_tick(MODE_PARK, 1'b0), 1'b0, '0);
		repeat ($urandom_range(1, 4))
			send_tick(scene_tick(MODE_PARK, 1'b1), 1'b0, '0);
		repeat ($urandom_range(0, 2))
			send_tick(scene_tick(MODE_DEFAULT_SW, 1'b1), 1'b0, '0);
		repeat ($urandom_range(1, 2))
			send_tick(scene_tick(MODE_DEFAULT, 1'b1), 1'b0, '0);
	endtask

	// anything goes: every mode code, random flags, lock_ack at random
	task automatic noise_burst();
		tick_t t;
		repeat ($urandom_range(1, 5)) begin
			t = scene_tick(MODE_W'($urandom), $urandom_range(0, 3) != 0);
			t.lock_ack     = 1'($urandom_range(0, 1));
			t.park_allowed = 1'($urandom_range(0, 1));
			t.fb_valid     = 1'($urandom_range(0, 1));
			send_tick(t, 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin
		int unsigned n_cyc;
		n_cyc = 0;
		while (n_cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			n_cyc++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		dir_row_t    dir_tab [$];
		int unsigned mark;

		arst_n               = 1'b0;
		tick_ch.valid        = 1'b0;
		tick_ch.lock_ack     = 1'b0;
		tick_ch.cmd_lin_x    = '0;
		tick_ch.cmd_lin_y    = '0;
		tick_ch.cmd_ang_z    = '0;
		tick_ch.cmd_steer    = '0;
		tick_ch.mode_state   = MODE_UNAVAIL;
		tick_ch.park_allowed = 1'b0;
		tick_ch.fb_valid     = 1'b0;
		tick_ch.fb_lin_x     = '0;
		tick_ch.fb_lin_y     = '0;
		tick_ch.fb_ang_z     = '0;
		tick_ch.now_ms       = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = REG_ENABLED;
		cfg_ch.data          = '0;

		// Directed table. Rows with fixed=1 carry a typed expectation: disabled
		// or unavailable/invalid mode, where the command simply passes through.
		// Out of reset the policy is disabled; lock_ack must be ignored.
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(1, 32767, -32768, 1, -1, MODE_PARK, 1, 1, 0, 0, 0, 32'h0), 1,
			rs(32767, -32768, 1, -1, 0, 0)});
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(0, -32768, 32767, -32768, 32767, MODE_INVALID, 0, 0, -32768, 32767, -1,
				32'hFFFF_FFFF), 1, rs(-32768, 32767, -32768, 32767, 0, 0)});
		// enable: zero command, stopped feedback starts the standstill timer
		dir_tab.push_back(dir_row_t'{1, REG_ENABLED, 1,
			tk(0, 0, 0, 0, 0, MODE_DEFAULT, 1, 1, 0, 0, 0, 1000), 0, '0});
		// delay of zero: lock at once
		dir_tab.push_back(dir_row_t'{1, REG_DELAY, 0,
			tk(0, 0, 0, 0, 0, MODE_DEFAULT, 1, 1, 0, 0, 0, 1000), 0, '0});
		// retry spacing: too soon, dropped
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(0, 0, 0, 0, 0, MODE_DEFAULT, 1, 1, 0, 0, 0, 1500), 0, '0});
		// feedback exactly at the stop limit, spacing met
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(0, 0, 0, 0, 0, MODE_DEFAULT, 1, 1, 10, -10, 10, 2000), 0, '0});
		// lock acknowledged, chassis switching to park
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(1, 0, 0, 0, 0, MODE_PARK_SW, 1, 1, 0, 0, 0, 2100), 0, '0});
		// full-scale command while parked: unlock request
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(0, 32767, -32768, 32767, -32768, MODE_PARK, 1, 1, 0, 0, 0, 3100), 0, '0});
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(0, 100, 0, 0, 0, MODE_DEFAULT_SW, 1, 1, 0, 0, 0, 3200), 0, '0});
		// back in default: unlock settled, command passes
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(0, 100, 0, 0, 0, MODE_DEFAULT, 1, 1, 0, 0, 0, 4200), 0, '0});
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(0, 5, -5, 0, 0, MODE_OTHER, 1, 1, 0, 0, 0, 4300), 0, '0});
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(0, 0, 0, 0, 0, MODE_DEFAULT, 0, 1, 0, 0, 0, 4400), 0, '0});
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(0, 0, 0, 0, 0, MODE_DEFAULT, 1, 0, 32767, -32768, 32767, 4500), 0, '0});
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(0, 1, 2, 3, 4, MODE_UNAVAIL, 1, 1, 0, 0, 0, 4600), 1, rs(1, 2, 3, 4, 0, 0)});
		dir_tab.push_back(dir_row_t'{0, REG_ENABLED, 0,
			tk(1, 1, 2, 3, 4, MODE_INVALID, 1, 1, 0, 0, 0, 4700), 1, rs(1, 2, 3, 4, 0, 0)});
		// filter weight below range and above one: clamped
		dir_tab.push_back(dir_row_t'{1, REG_ALPHA, 0,
			tk(0, -32768, -32768, -32768, -32768, MODE_DEFAULT, 1, 1, 0, 0, 0, 5000), 0, '0});
		dir_tab.push_back(dir_row_t'{1, REG_ALPHA, 17'h1FFFF,
			tk(0, 1234, -1234, 77, -77, MODE_DEFAULT, 1, 1, 0, 0, 0, 5100), 0, '0});
		// widest command limits: full-scale command snaps to zero
		dir_tab.push_back(dir_row_t'{1, REG_CMD_LIN_LIM, 32767,
			tk(0, 32767, -32767, 0, 0, MODE_DEFAULT, 1, 1, 0, 0, 0, 5200), 0, '0});
		dir_tab.push_back(dir_row_t'{1, REG_CMD_ANG_LIM, 32767,
			tk(0, 0, 0, -32767, 32767, MODE_DEFAULT, 1, 1, 0, 0, 0, 5300), 0, '0});
		// time about to wrap: standstill still timed, lock request just below 2^32
		dir_tab.push_back(dir_row_t'{1, REG_FB_LIN_LIM, 32767,
			tk(0, 0, 0, 0, 0, MODE_DEFAULT, 1, 1, 32767, -32767, 0, 32'hFFFF_FF00), 0, '0});
		// after the wrap: retry spacing holds across it, the request is dropped
		dir_tab.push_back(dir_row_t'{1, REG_FB_ANG_LIM, 0,
			tk(0, 0, 0, 0, 0, MODE_DEFAULT, 1, 1, -32767, 32767, 0, 32'h0000_0010), 0, '0});
		dir_tab.push_back(dir_row_t'{1, REG_CMD_LIN_LIM, 0,
			tk(1, 500, 0, 0, 0, MODE_PARK, 1, 1, 0, 0, 0, 32'h0000_0500), 0, '0});
		// auto-unlock off: parked command is held at zero, no request
		dir_tab.push_back(dir_row_t'{1, REG_AUTO_UNLOCK, 0,
			tk(0, 500, 0, 0, 0, MODE_PARK, 1, 1, 0, 0, 0, 32'h0000_1000), 0, '0});
		dir_tab.push_back(dir_row_t'{1, REG_ENABLED, 0,
			tk(1, -1, -1, -1, -1, MODE_PARK, 1, 1, 0, 0, 0, 32'h0000_2000), 1,
			rs(-1, -1, -1, -1, 0, 0)});

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].wr) begin
				drain();
				write_reg(dir_tab[i].idx, dir_tab[i].val);
				cfg_ch.valid <= 1'b0;
			end
			send_tick(dir_tab[i].t, dir_tab[i].fixed, dir_tab[i].r);
		end

		// Random phases. Registers change only once the block has drained.
		clock_ms = 32'd10000;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			quiet    = (ph == 4);
			hold_ask = (ph == 5);
			case (ph)
				0: apply_settings(1, 1, 0, ALPHA_MIN, 0, 0, 0, 0);
				1: apply_settings(1, 0, 65535, ALPHA_ONE, 32767, 32767, 32767, 32767);
				2: apply_settings(1, 1, 300, 0, 20, 20, 20, 20);
				3: apply_settings(0, 1, 500, 6554, 10, 10, 10, 10);
				default: apply_settings($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
					$urandom_range(0, 1500),
					(ph == 7) ? $urandom_range(0, 131071) : $urandom_range(656, 65536),
					$urandom_range(0, 200), $urandom_range(0, 200),
					$urandom_range(0, 200), $urandom_range(0, 200));
			endcase
			if (ph == 6)
				clock_ms = 32'hFFFF_F000;    // this phase runs across the time wrap
			mark = sent_cnt;
			while (sent_cnt - mark < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < 75)
					park_cycle();
				else
					noise_burst();
			end
		end

		drain();
		quiet = 1'b0;
		// extra settling time before the final check for missing results
		repeat (8) @(negedge clk);
		if (due_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, due_results.size());
			fault_cnt++;
		end
		if (fault_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
